// ===== design/bmg_pkg.sv =====
// Shared types, constants and helpers of the Box-Muller Gaussian pair unit.
package bmg_pkg;

	localparam logic [63:0] LN2X2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;
	localparam logic [63:0] PI_Q62    = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
	localparam int LOG_STEPS  = 56;
	localparam int SQRT_STEPS = 61;
	localparam int TRIG_TERMS = 10;

	typedef struct packed {
		logic [5:0]  e;
		logic [63:0] f;
		logic [55:0] frac;
	} bmg_log_t;

	typedef struct packed {
		logic [127:0] rem;
		logic [60:0]  r;
	} bmg_sqrt_t;

	typedef struct packed {
		logic [2:0]  oct;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] ss;
		logic [63:0] sc;
	} bmg_trig_t;

	// 32x32 partial products of a 64x64 product, packed {hh, hl, lh, ll}
	function automatic logic [255:0] mul_parts(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] hh, hl, lh, ll;
		hh = 64'(a[63:32]) * 64'(b[63:32]);
		hl = 64'(a[63:32]) * 64'(b[31:0]);
		lh = 64'(a[31:0]) * 64'(b[63:32]);
		ll = 64'(a[31:0]) * 64'(b[31:0]);
		return {hh, hl, lh, ll};
	endfunction

	// full 128-bit product from the partial products
	function automatic logic [127:0] sum_parts(input logic [255:0] pp);
		return {64'b0, pp[63:0]} + {32'b0, pp[127:64], 32'b0} + {32'b0, pp[191:128], 32'b0}
			+ {pp[255:192], 64'b0};
	endfunction

endpackage

// ===== design/box_muller_gaussian_pair_unit.sv =====
// Box-Muller Gaussian pair unit: top level.
// Input stream: s_tdata carries two 48-bit random words, the radius word in
// bits 47:0 and the angle word in bits 95:48. Each transfer yields two
// output transfers on m_tdata (signed deviate, Q4.27 by default): the cosine
// term first, then the sine term with m_tlast high.
// Depth: 176 radius stages (input, log cells, scaling, square root), then
// the output product stage and the output pair register; the cosine term is
// offered first, the sine term in the cycle after the cosine term is taken.
// Throughput: one deviate every cycle while m_tready is high, one input per
// pair; set by the single output pair register that emits its two deviates
// one at a time. The angle word waits in a 131-entry delay memory, then runs
// through the octant reduction and ten Taylor cells to meet the radius.
// Reset clears the valid bits, the pair flags and the delay pointer.
// When the receiver stalls, the whole chain holds and s_tready falls; no
// transfer is lost.
module box_muller_gaussian_pair_unit import bmg_pkg::*; #(
	parameter int UNIFORM_BITS = 48,
	parameter int OUT_WIDTH    = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [95:0] s_tdata, // uniform_radius_word[47:0], uniform_angle_word[95:48]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((OUT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata, // normal_value
	output logic m_tlast // is_last
);
	localparam int RDEPTH = 1 + 2 * LOG_STEPS + 2 + SQRT_STEPS;
	localparam int DEPTH = RDEPTH + 1;
	localparam int TDEPTH = 4 + 4 * TRIG_TERMS;
	localparam int ADLY = RDEPTH - TDEPTH - 1;
	localparam int AW = $clog2(ADLY);
	localparam int SH = 123 - OUT_WIDTH;
	localparam int OW8 = ((OUT_WIDTH + 7) / 8) * 8;

	logic adv;
	logic [DEPTH-1:0] vld_q;
	logic pair_q, phase_q;
	logic [OUT_WIDTH-1:0] cos_q, sin_q;

	bmg_log_t  log_s[LOG_STEPS+1];
	bmg_sqrt_t sqrt_s[SQRT_STEPS+1];
	bmg_trig_t trig_s[TRIG_TERMS+1];
	logic [47:0] ang_mem[ADLY];
	logic [AW-1:0] wptr_q;
	logic [47:0] adly_q;
	logic [2:0]  oct_s1, oct_s2, oct_s3;
	logic [255:0] apart_s1, x2part_s3;
	logic [63:0] ang_s2, ang_s3;

	// radius and angle prep
	logic [UNIFORM_BITS:0] m_w;
	logic [5:0] e_w;
	logic [UNIFORM_BITS:0] y_w;
	logic [63:0] p_w;
	logic [61:0] fr_w;
	bmg_log_t lp_w;

	always_comb begin
		m_w = {s_tdata[UNIFORM_BITS-1:0], 1'b1};
		e_w = '0;
		for (int i = 0; i <= UNIFORM_BITS; i++) begin
			if (m_w[i]) e_w = 6'(i);
		end
		lp_w.e    = e_w;
		lp_w.f    = 64'(m_w) << (6'd62 - e_w);
		lp_w.frac = '0;
		y_w  = {adly_q[UNIFORM_BITS-1:0], 1'b1};
		p_w  = 64'(y_w) << (63 - UNIFORM_BITS);
		fr_w = p_w[61] ? (62'h2000_0000_0000_0000 - {1'b0, p_w[60:0]}) : {1'b0, p_w[60:0]};
	end

	assign adv = !pair_q || (m_tready && phase_q);
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			pair_q  <= 1'b0;
			phase_q <= 1'b0;
			wptr_q  <= '0;
		end else begin
			if (adv) begin
				vld_q   <= {vld_q[DEPTH-2:0], s_tvalid};
				pair_q  <= vld_q[DEPTH-1];
				phase_q <= 1'b0;
				wptr_q  <= (wptr_q == AW'(ADLY - 1)) ? '0 : wptr_q + 1'b1;
			end else if (m_tvalid && m_tready) begin
				phase_q <= 1'b1;
			end
		end
	end

	// angle word waits here until its trig terms can meet the radius
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_mem[wptr_q] <= s_tdata[95:48];
			adly_q          <= ang_mem[wptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			log_s[0] <= lp_w;
			oct_s1   <= p_w[63:61];
			apart_s1 <= mul_parts(64'(fr_w), PI_Q62);
			oct_s2   <= oct_s1;
			ang_s2   <= 64'(sum_parts(apart_s1) >> 63);
			oct_s3   <= oct_s2;
			ang_s3   <= ang_s2;
			x2part_s3 <= mul_parts(ang_s2, ang_s2);
		end
	end

	// angle chain
	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s[0].oct <= oct_s3;
			trig_s[0].x2  <= 64'(sum_parts(x2part_s3) >> 62);
			trig_s[0].ts  <= ang_s3;
			trig_s[0].ss  <= ang_s3;
			trig_s[0].tc  <= ONE_Q62;
			trig_s[0].sc  <= ONE_Q62;
		end
	end

	for (genvar k = 1; k <= TRIG_TERMS; k++) begin : g_trig
		bmg_trig_cell #(.K(k)) u_cell (
			.clk(clk), .en(adv), .din(trig_s[k-1]), .dout(trig_s[k])
		);
	end

	// radius chain
	for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
		bmg_log_cell u_cell (
			.clk(clk), .en(adv), .din(log_s[i-1]), .dout(log_s[i])
		);
	end

	logic [63:0] t_w, s_w;
	logic [255:0] tpart_s1;
	always_comb begin
		t_w = (64'(UNIFORM_BITS + 1) << 56) - {2'b0, log_s[LOG_STEPS].e, log_s[LOG_STEPS].frac};
		s_w = 64'(sum_parts(tpart_s1) >> 62);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tpart_s1      <= mul_parts(t_w, LN2X2_Q62);
			sqrt_s[0].rem <= {8'b0, s_w, 56'b0};
			sqrt_s[0].r   <= '0;
		end
	end

	for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_sqrt
		bmg_sqrt_cell #(.B(SQRT_STEPS - i)) u_cell (
			.clk(clk), .en(adv), .din(sqrt_s[i-1]), .dout(sqrt_s[i])
		);
	end

	// output scaling
	bmg_trig_t tr_w;
	logic swap_w, sneg_w, cneg_w;
	logic cneg_s1, sneg_s1;
	logic [255:0] cpart_s1, sinpart_s1;
	logic [63:0] cv_w, sv_w, cq_w, sq_w;
	logic [127:0] cp_w, sp_w;

	always_comb begin
		tr_w   = trig_s[TRIG_TERMS];
		swap_w = tr_w.oct[0] ^ tr_w.oct[1];
		cneg_w = tr_w.oct[2] ^ tr_w.oct[1];
		sneg_w = tr_w.oct[2];
		cv_w   = swap_w ? tr_w.ss : tr_w.sc;
		sv_w   = swap_w ? tr_w.sc : tr_w.ss;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cpart_s1   <= mul_parts({3'b0, sqrt_s[SQRT_STEPS].r}, cv_w);
			sinpart_s1 <= mul_parts({3'b0, sqrt_s[SQRT_STEPS].r}, sv_w);
			cneg_s1    <= cneg_w;
			sneg_s1    <= sneg_w;
		end
	end

	always_comb begin
		cp_w = sum_parts(cpart_s1) + (128'b1 << (SH - 1));
		sp_w = sum_parts(sinpart_s1) + (128'b1 << (SH - 1));
		cq_w = 64'(cp_w >> SH);
		sq_w = 64'(sp_w >> SH);
		if (cneg_s1) cq_w = 64'b0 - cq_w;
		if (sneg_s1) sq_w = 64'b0 - sq_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_q <= cq_w[OUT_WIDTH-1:0];
			sin_q <= sq_w[OUT_WIDTH-1:0];
		end
	end

	assign m_tvalid = pair_q;
	assign m_tlast  = phase_q;
	assign m_tdata  = OW8'(phase_q ? sin_q : cos_q);

	a_no_accept_mid_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pair_q && !phase_q |-> !s_tready) else $error("input taken while pair pending");
	a_cos_then_sin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
		else $error("sine term missing after cosine");
	a_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DEPTH-1] && !adv |=> vld_q[DEPTH-1]) else $error("stalled result dropped");
	a_load_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[DEPTH-1] |=> m_tvalid && !m_tlast) else $error("pair not loaded");
endmodule

// ===== design/bmg_log_cell.sv =====
// One squaring step of the bit-serial base-2 logarithm, held in a product register and an output register.
module bmg_log_cell import bmg_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  bmg_log_t din,
	output bmg_log_t dout
);
	logic [5:0]   e_s1;
	logic [55:0]  frac_s1;
	logic [255:0] prod_s1;
	logic [63:0]  sq;
	bmg_log_t     nxt;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= din.e;
			frac_s1 <= din.frac;
			prod_s1 <= mul_parts(din.f, din.f);
			dout    <= nxt;
		end
	end

	always_comb begin
		sq       = 64'(sum_parts(prod_s1) >> 62);
		nxt.e    = e_s1;
		nxt.frac = {frac_s1[54:0], sq[63]};
		nxt.f    = sq[63] ? {1'b0, sq[63:1]} : sq;
	end
endmodule

// ===== design/bmg_sqrt_cell.sv =====
// One result bit of the restoring square root.
module bmg_sqrt_cell import bmg_pkg::*; #(
	parameter int B = 0
) (
	input  logic      clk,
	input  logic      en,
	input  bmg_sqrt_t din,
	output bmg_sqrt_t dout
);
	logic [127:0] trial;
	bmg_sqrt_t    nxt;

	always_comb begin
		trial = ({67'b0, din.r} << (B + 1)) | (128'b1 << (2 * B));
		nxt   = din;
		if (din.rem >= trial) begin
			nxt.rem = din.rem - trial;
			nxt.r   = din.r | (61'b1 << B);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

// ===== design/bmg_trig_cell.sv =====
// One Taylor term of sine and cosine, held in product, sum, quotient and output registers.
module bmg_trig_cell import bmg_pkg::*; #(
	parameter int K = 1
) (
	input  logic      clk,
	input  logic      en,
	input  bmg_trig_t din,
	output bmg_trig_t dout
);
	localparam int DivS = (2 * K) * (2 * K + 1);
	localparam int DivC = (2 * K - 1) * (2 * K);
	localparam int LS = $clog2(DivS);
	localparam int LC = $clog2(DivC);
	// ceil(2^(62+l)/d): exact truncating division of any value below 2^62
	localparam logic [63:0] RecipS =
		64'(((128'd1 << (62 + LS)) + 128'(DivS - 1)) / 128'(DivS));
	localparam logic [63:0] RecipC =
		64'(((128'd1 << (62 + LC)) + 128'(DivC - 1)) / 128'(DivC));

	bmg_trig_t    t_s1, t_s2, t_s3;
	logic [255:0] sprod_s1, cprod_s1, squo_s3, cquo_s3;
	logic [63:0]  ts_s2, tc_s2;
	logic [63:0]  ts_w, tc_w;
	bmg_trig_t    nxt;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= din;
			sprod_s1 <= mul_parts(din.ts, din.x2);
			cprod_s1 <= mul_parts(din.tc, din.x2);
			t_s2     <= t_s1;
			ts_s2    <= 64'(sum_parts(sprod_s1) >> 62);
			tc_s2    <= 64'(sum_parts(cprod_s1) >> 62);
			t_s3     <= t_s2;
			squo_s3  <= mul_parts(ts_s2, RecipS);
			cquo_s3  <= mul_parts(tc_s2, RecipC);
			dout     <= nxt;
		end
	end

	always_comb begin
		ts_w   = 64'(sum_parts(squo_s3) >> (62 + LS));
		tc_w   = 64'(sum_parts(cquo_s3) >> (62 + LC));
		nxt    = t_s3;
		nxt.ts = ts_w;
		nxt.tc = tc_w;
		if (K % 2 == 1) begin
			nxt.ss = t_s3.ss - ts_w;
			nxt.sc = t_s3.sc - tc_w;
		end else begin
			nxt.ss = t_s3.ss + ts_w;
			nxt.sc = t_s3.sc + tc_w;
		end
	end
endmodule
